// ----- hdl/itw_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// itw_pkg: shared types and constants for the integer to word tokens unit
// Field widths, token codes and the record passed from the converter to the
// token sequencer.
// ============================================================================
package itw_pkg;

   localparam int unsigned VALUE_W = 31;   // width of the input value
   localparam int unsigned DIGITS  = 10;   // decimal digits of a 31-bit value
   localparam int unsigned CODE_W  = 5;    // width of a word token
   localparam int unsigned SHIFT_W = 5;    // counts the converter's shift steps

   localparam logic [CODE_W-1:0] CODE_ZERO     = 5'd0;
   localparam logic [CODE_W-1:0] CODE_TEN      = 5'd10;
   localparam logic [CODE_W-1:0] CODE_TENS_OFS = 5'd18;  // tens digit t maps to 18 + t
   localparam logic [CODE_W-1:0] CODE_HUNDRED  = 5'd28;
   localparam logic [CODE_W-1:0] CODE_THOUSAND = 5'd29;
   localparam logic [CODE_W-1:0] CODE_MILLION  = 5'd30;
   localparam logic [CODE_W-1:0] CODE_BILLION  = 5'd31;

   typedef logic [DIGITS-1:0][3:0] digits_type;

   typedef struct packed {
      logic       done;     // one-cycle pulse, digits are valid
      digits_type digits;   // digit 0 is the least significant
   } bcd_result_type;

endpackage

// ----- hdl/itw_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// itw_if: channel interfaces of the integer to word tokens unit
// One interface carries input items, the other carries word tokens.
// ============================================================================
interface itw_req_if;
   logic                          valid;
   logic                          ready;
   logic [itw_pkg::VALUE_W-1:0]   value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface itw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [itw_pkg::CODE_W-1:0]    word_code;
   logic                          last_word;

   modport source (output valid, output word_code, output last_word, input ready);
   modport sink   (input valid, input word_code, input last_word, output ready);
endinterface

// ----- hdl/itw_bcd.sv -----
`timescale 1ns / 1ps
// ============================================================================
// itw_bcd: iterative binary to decimal converter
// One shift-and-add-three step per cycle over the 31 bits of the value.
// ============================================================================
module itw_bcd (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [itw_pkg::VALUE_W-1:0]   value,
   output logic                          busy,
   output itw_pkg::bcd_result_type       result
);

   localparam logic [itw_pkg::SHIFT_W-1:0] LAST_STEP = itw_pkg::SHIFT_W'(itw_pkg::VALUE_W - 1);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [itw_pkg::SHIFT_W-1:0]        cnt_ff, cnt_in;
   logic [itw_pkg::VALUE_W-1:0]        bin_ff, bin_in;
   itw_pkg::digits_type                bcd_ff, bcd_in;
   itw_pkg::digits_type                adj;

   // Add three to every digit of five or more, then shift one bit in.
   always_comb begin
      for (int i = 0; i < itw_pkg::DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         bin_in  = value;
         bcd_in  = '0;
      end else if (busy_ff) begin
         // The top bit shifted out is always zero: the leading digit of a
         // 31-bit value never exceeds two.
         bcd_in = {adj[itw_pkg::DIGITS-1][2:0], adj[itw_pkg::DIGITS-2:0],
                   bin_ff[itw_pkg::VALUE_W-1]};
         bin_in = {bin_ff[itw_pkg::VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign busy          = busy_ff;
   assign result.done   = done_ff;
   assign result.digits = bcd_ff;

endmodule

// ----- hdl/itw_seq.sv -----
`timescale 1ns / 1ps
// ============================================================================
// itw_seq: word token sequencer
// Walks the four digit groups and five token slots per group, holding one
// token back so that the final token can be flagged.
// ============================================================================
module itw_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  itw_pkg::bcd_result_type    bcd,
   output logic                       idle,
   itw_rsp_if.source                  rsp_ch
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   localparam logic [2:0] SLOT_HUN_DIGIT = 3'd0;
   localparam logic [2:0] SLOT_HUNDRED   = 3'd1;
   localparam logic [2:0] SLOT_REM       = 3'd2;
   localparam logic [2:0] SLOT_UNITS     = 3'd3;
   localparam logic [2:0] SLOT_SCALE     = 3'd4;

   localparam logic [1:0] GRP_BILLION  = 2'd0;
   localparam logic [1:0] GRP_MILLION  = 2'd1;
   localparam logic [1:0] GRP_THOUSAND = 2'd2;
   localparam logic [1:0] GRP_UNITS    = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [1:0]                   grp_ff, grp_in;
   logic [2:0]                   slot_ff, slot_in;
   itw_pkg::digits_type          dig_ff, dig_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [itw_pkg::CODE_W-1:0]   pend_code_ff, pend_code_in;
   logic                         out_valid_ff, out_valid_in;
   logic [itw_pkg::CODE_W-1:0]   out_code_ff, out_code_in;
   logic                         out_last_ff, out_last_in;

   logic [3:0]                   hun, ten, one;
   logic                         grp_nz;
   logic                         tok_en;
   logic [itw_pkg::CODE_W-1:0]   tok_code;
   logic                         advance;

   // Digits of the current group; the billion group has only its ones digit.
   always_comb begin
      case (grp_ff)
         GRP_BILLION: begin
            hun = 4'd0;       ten = 4'd0;       one = dig_ff[9];
         end
         GRP_MILLION: begin
            hun = dig_ff[8];  ten = dig_ff[7];  one = dig_ff[6];
         end
         GRP_THOUSAND: begin
            hun = dig_ff[5];  ten = dig_ff[4];  one = dig_ff[3];
         end
         default: begin
            hun = dig_ff[2];  ten = dig_ff[1];  one = dig_ff[0];
         end
      endcase
   end

   assign grp_nz = (hun != 4'd0) || (ten != 4'd0) || (one != 4'd0);

   // Token of the current slot, if the slot produces one.
   always_comb begin
      tok_en   = 1'b0;
      tok_code = itw_pkg::CODE_ZERO;
      case (slot_ff)
         SLOT_HUN_DIGIT: begin
            tok_en   = (hun != 4'd0);
            tok_code = {1'b0, hun};
         end
         SLOT_HUNDRED: begin
            tok_en   = (hun != 4'd0);
            tok_code = itw_pkg::CODE_HUNDRED;
         end
         SLOT_REM: begin
            if (ten < 4'd2) begin
               tok_en   = (ten != 4'd0) || (one != 4'd0);
               tok_code = ten[0] ? itw_pkg::CODE_TEN + {1'b0, one} : {1'b0, one};
            end else begin
               tok_en   = 1'b1;
               tok_code = itw_pkg::CODE_TENS_OFS + {1'b0, ten};
            end
         end
         SLOT_UNITS: begin
            tok_en   = (ten >= 4'd2) && (one != 4'd0);
            tok_code = {1'b0, one};
         end
         SLOT_SCALE: begin
            tok_en = grp_nz && (grp_ff != GRP_UNITS);
            case (grp_ff)
               GRP_BILLION:  tok_code = itw_pkg::CODE_BILLION;
               GRP_MILLION:  tok_code = itw_pkg::CODE_MILLION;
               default:      tok_code = itw_pkg::CODE_THOUSAND;
            endcase
         end
         default: begin
            tok_en   = 1'b0;
            tok_code = itw_pkg::CODE_ZERO;
         end
      endcase
   end

   assign advance = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in      = state_ff;
      grp_in        = grp_ff;
      slot_in       = slot_ff;
      dig_in        = dig_ff;
      pend_valid_in = pend_valid_ff;
      pend_code_in  = pend_code_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_code_in   = out_code_ff;
      out_last_in   = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (bcd.done) begin
               state_in      = ST_RUN;
               dig_in        = bcd.digits;
               grp_in        = GRP_BILLION;
               slot_in       = SLOT_HUN_DIGIT;
               pend_valid_in = 1'b0;
            end
         end
         ST_RUN: begin
            if (advance) begin
               if (tok_en) begin
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_code_in  = pend_code_ff;
                     out_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_code_in  = tok_code;
               end
               if (slot_ff == SLOT_SCALE) begin
                  slot_in = SLOT_HUN_DIGIT;
                  grp_in  = grp_ff + 1'b1;
                  if (grp_ff == GRP_UNITS) begin
                     state_in = ST_FLUSH;
                  end
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (advance) begin
               // A value of zero leaves nothing pending and spells Zero.
               out_valid_in  = 1'b1;
               out_code_in   = pend_valid_ff ? pend_code_ff : itw_pkg::CODE_ZERO;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      grp_ff       <= grp_in;
      slot_ff      <= slot_in;
      dig_ff       <= dig_in;
      pend_code_ff <= pend_code_in;
      out_code_ff  <= out_code_in;
      out_last_ff  <= out_last_in;
   end

   assign idle             = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.word_code = out_code_ff;
   assign rsp_ch.last_word = out_last_ff;

endmodule

// ----- hdl/integer_to_word_tokens_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// integer_to_word_tokens_unit: spells an integer as English word tokens
// Converts a 31-bit value to decimal and emits its word tokens, largest
// group first, with the final token flagged.
// ============================================================================
// The req_ch channel takes one item, a 31-bit unsigned value. The rsp_ch
// channel returns a run of one to sixteen items, each a 5-bit word code
// (Zero..Nineteen, Twenty..Ninety, Hundred, Thousand, Million, Billion) and a
// last_word flag that is set on the final item of the run.
//
// An accepted value first passes through a shift-and-add-three converter
// that takes one bit per cycle. A sequencer then visits the billion,
// million, thousand and units groups, five token slots each, one slot per
// cycle while the receiver does not stall it, and a final flush step
// releases the last token. Since one token is held back, the first token
// is offered only once a second one is found, or at the flush.
// req_ch.ready stays low while an item is converted, handed over or sequenced.
//
// A stalled receiver freezes the sequencer; tokens are never dropped. The
// last token may still wait in the output register while the next value is
// accepted. Synchronous reset empties the converter, sequencer and output
// register; there is no other state to clear.
// ============================================================================
module integer_to_word_tokens_unit (
   input  logic         clock,
   input  logic         reset,
   itw_req_if.sink      req_ch,
   itw_rsp_if.source    rsp_ch
);

   logic                        bcd_busy;
   logic                        seq_idle;
   logic                        start;
   itw_pkg::bcd_result_type     bcd_result;

   // Accept only when both the converter and the sequencer are free, and not
   // in the cycle where the converter hands its digits to the sequencer.
   assign req_ch.ready = !bcd_busy && !bcd_result.done && seq_idle;
   assign start        = req_ch.valid && req_ch.ready;

   itw_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .value  (req_ch.value),
      .busy   (bcd_busy),
      .result (bcd_result)
   );

   itw_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .bcd    (bcd_result),
      .idle   (seq_idle),
      .rsp_ch (rsp_ch)
   );

endmodule

// ----- hdl/itw_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// itw_checker: port-level checks for the integer to word tokens unit
// Watches both channels and reports violations.
// ============================================================================
module itw_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [itw_pkg::CODE_W-1:0]    rsp_word_code,
   input logic                          rsp_last_word
);

   // A waiting token stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before the item was taken");

   // A waiting token does not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_word_code) && $stable(rsp_last_word))
      else $error("rsp payload changed while stalled");

   // The block works on one value at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req ready held after an item was accepted");

   // When the block is free, only the final token of a run may still wait.
   assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_last_word)
      else $error("unfinished token run while ready for a new item");

endmodule

bind integer_to_word_tokens_unit itw_checker u_itw_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_word_code (rsp_ch.word_code),
   .rsp_last_word (rsp_ch.last_word)
);

// ----- verif/tb_integer_to_word_tokens_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_integer_to_word_tokens_unit: self-checking bench for the word token unit
// Sends directed and random values and spells each one in the bench's own
// model. Every token that comes back is compared, code and last flag, with
// the oldest expected token. Both sides idle at random. The receiver also
// holds off for a long stretch once, and the sender waits for the block
// to drain once mid-run and again at the end.
// ============================================================================
module tb_integer_to_word_tokens_unit;

   localparam int unsigned RANDOM_ITEMS = 460;
   localparam int unsigned IDLE_PCT     = 14;
   localparam int unsigned HOLD_CYCLES  = 400;  // long receiver hold-off
   localparam int unsigned DRAIN_CYCLES = 80;   // extra wait after the final drain
   localparam int unsigned QUIET_LIMIT  = 4000; // cycles with no handshake at all
   localparam logic [itw_pkg::VALUE_W-1:0] VALUE_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [itw_pkg::CODE_W-1:0] code;
      logic                       last;
   } word_token_type;

   // Holds the tokens that the block still owes and spells each accepted
   // value into that store.
   class spelling_scoreboard;
      word_token_type expected_words[$];
      int unsigned errors = 0;

      function int unsigned pending();
         return expected_words.size();
      endfunction

      task report(string msg);
         $display("%0t ns mismatch: %s", $realtime, msg);
         errors++;
      endtask

      // Splits the value into billion, million, thousand and units groups and
      // spells each non-zero group: hundreds, then a word below twenty or a
      // tens word with an optional units word, then the scale word, if the group has one.
      function void note_value(logic [itw_pkg::VALUE_W-1:0] value);
         int unsigned                v;
         int unsigned                grp;
         int unsigned                hun;
         int unsigned                rem;
         int unsigned                n;
         int unsigned                divisor [4];
         logic [itw_pkg::CODE_W-1:0] scale [4];
         logic [itw_pkg::CODE_W-1:0] codes [16];
         word_token_type             tok;
         divisor = '{1000000000, 1000000, 1000, 1};
         scale   = '{itw_pkg::CODE_BILLION, itw_pkg::CODE_MILLION,
                     itw_pkg::CODE_THOUSAND, itw_pkg::CODE_ZERO};
         v = value;
         n = 0;
         if (v == 0) begin
            codes[0] = itw_pkg::CODE_ZERO;
            n = 1;
         end
         for (int g = 0; g < 4; g++) begin
            grp = (v / divisor[g]) % 1000;
            if (grp != 0) begin
               hun = grp / 100;
               rem = grp % 100;
               if (hun != 0) begin
                  codes[n] = itw_pkg::CODE_W'(hun);
                  codes[n+1] = itw_pkg::CODE_HUNDRED;
                  n += 2;
               end
               if (rem >= 20) begin
                  codes[n] = itw_pkg::CODE_W'(itw_pkg::CODE_TENS_OFS + rem / 10);
                  n++;
                  if (rem % 10 != 0) begin
                     codes[n] = itw_pkg::CODE_W'(rem % 10);
                     n++;
                  end
               end else if (rem != 0) begin
                  codes[n] = itw_pkg::CODE_W'(rem);
                  n++;
               end
               if (g < 3) begin
                  codes[n] = scale[g];
                  n++;
               end
            end
         end
         for (int i = 0; i < n; i++) begin
            tok.code = codes[i];
            tok.last = (i == n - 1);
            expected_words.push_back(tok);
         end
      endfunction

      task check_word(logic [itw_pkg::CODE_W-1:0] code, logic last);
         word_token_type want;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected token code %0d last %0b", code, last));
         end else begin
            want = expected_words.pop_front();
            if (code !== want.code)
               report($sformatf("word_code %0d, expected %0d", code, want.code));
            if (last !== want.last)
               report($sformatf("last_word %0b, expected %0b (code %0d)",
                                last, want.last, want.code));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   itw_req_if req_ch ();
   itw_rsp_if rsp_ch ();

   integer_to_word_tokens_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   spelling_scoreboard spelled = new();

   bit          steady       = 1'b0;  // no idling on either side while set
   bit          hold_pending = 1'b0;  // asks the receiver for one long hold-off
   int unsigned quiet_cycles = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Both handshakes are sampled at the edge, before any new drive lands.
   // The watchdog counts edges at which neither side moved an item.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            spelled.note_value(req_ch.value);
         if (rsp_ch.valid && rsp_ch.ready)
            spelled.check_word(rsp_ch.word_code, rsp_ch.last_word);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= QUIET_LIMIT) begin
               $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
               $display("tb_integer_to_word_tokens_unit: FAIL");
               $finish;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Offers one value, idling first at random, and returns at the edge
   // where it is accepted. Valid stays high when the next value follows.
   task send_value(logic [itw_pkg::VALUE_W-1:0] v);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Drops valid and waits until every owed token has come back.
   task wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (spelled.pending() != 0);
   endtask

   // Random values: half built group by group so that zero groups, teens,
   // round tens and hundreds all show up; the rest is full-range noise,
   // small numbers, powers of ten and the top of the range.
   function automatic logic [itw_pkg::VALUE_W-1:0] pick_value();
      longint      acc;
      int unsigned grp;
      int unsigned mode;
      mode = $urandom_range(9);
      case (mode)
         0, 1: return itw_pkg::VALUE_W'($urandom());
         7:    return itw_pkg::VALUE_W'($urandom_range(120));
         8:    return itw_pkg::VALUE_W'(10 ** $urandom_range(9) + $urandom_range(2) - 1);
         9:    return VALUE_MAX - itw_pkg::VALUE_W'($urandom_range(1000));
         default: begin
            acc = $urandom_range(2);
            for (int g = 0; g < 3; g++) begin
               case ($urandom_range(9))
                  0, 1, 2: grp = 0;
                  3:       grp = $urandom_range(19);
                  4:       grp = $urandom_range(9) * 10 + $urandom_range(9) * 100;
                  default: grp = $urandom_range(999);
               endcase
               acc = acc * 1000 + grp;
            end
            // Two billion and more can overflow the field; fall back to one.
            if (acc > longint'(VALUE_MAX))
               acc -= 1000000000;
            return itw_pkg::VALUE_W'(acc);
         end
      endcase
   endfunction

   initial begin
      int unsigned directed [$];
      directed = '{0, 1, 9, 10, 11, 19, 20, 21, 99, 100, 101, 110, 119, 120, 999,
                   1000, 1001, 1000000, 1000010, 1000000000, 2000000000,
                   1777777777, 1234567890, 2147483647};
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      while (reset) @(posedge clock);

      foreach (directed[i])
         send_value(itw_pkg::VALUE_W'(directed[i]));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 60)
            hold_pending = 1'b1;   // sender keeps offering while tokens back up
         steady = (i >= 150 && i < 250);
         if (i == 300)
            wait_drained();
         send_value(pick_value());
      end
      steady = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (spelled.errors == 0 && spelled.pending() == 0) begin
         $display("tb_integer_to_word_tokens_unit: PASS");
      end else begin
         $display("tb_integer_to_word_tokens_unit: FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/itw_pkg.sv
hdl/itw_if.sv
hdl/itw_bcd.sv
hdl/itw_seq.sv
hdl/integer_to_word_tokens_unit.sv
hdl/itw_checker.sv
verif/tb_integer_to_word_tokens_unit.sv
